[rtl/gsb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsb_pkg
// Shared widths, register indexes and types of the single-bin goertzel block.
// ----------------------------------------------------------------------------
package gsb_pkg;

  localparam int MAX_BLOCK = 4096;
  localparam int SAMPLE_W  = 16;
  localparam int BLEN_W    = 13;
  localparam int CNT_W     = $clog2(MAX_BLOCK + 1);
  localparam int COEF_W    = 32;
  localparam int RECIP_W   = 31;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int DLY_W     = 48;
  localparam int OUT_W     = 40;
  localparam int X_SHIFT   = 8;

  // shared multiplier: a-operand split into signed high part and 24-bit low part
  localparam int OPA_W  = 50;
  localparam int OPB_W  = COEF_W + 1;
  localparam int LO_W   = 24;
  localparam int HI_W   = OPA_W - LO_W;
  localparam int PROD_W = HI_W + OPB_W;
  localparam int FULL_W = PROD_W + LO_W;
  localparam int SH_REC = 29;
  localparam int SH_CS  = 30;
  localparam int SH_OUT = 22;
  localparam int RES_W  = FULL_W - SH_OUT;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_LENGTH = 2'd0,
    REG_COS_COEFF    = 2'd1,
    REG_SIN_COEFF    = 2'd2,
    REG_HALF_RECIP   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] cos_coeff;
    logic signed [COEF_W-1:0] sin_coeff;
    logic        [RECIP_W-1:0] recip;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } qent_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } qstat_t;

endpackage
`default_nettype wire

[rtl/gsb_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsb_front
// Takes samples, counts them against the block length and tags the last one.
// ----------------------------------------------------------------------------
module gsb_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [gsb_pkg::SAMPLE_W-1:0] sample_i,
  input  logic        [gsb_pkg::BLEN_W-1:0]   block_length_i,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output gsb_pkg::qent_t                      q_entry_o
);
  import gsb_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] len_eff;
  logic [CNT_W-1:0] cnt_next;
  logic             last;

  always_comb begin
    if (block_length_i == '0) begin
      len_eff = CNT_W'(1);
    end else if (block_length_i > BLEN_W'(MAX_BLOCK)) begin
      len_eff = CNT_W'(MAX_BLOCK);
    end else begin
      len_eff = CNT_W'(block_length_i);
    end
  end

  // a lowered length ends the block on the next sample
  assign cnt_next = count_q + 1'b1;
  assign last     = (cnt_next >= len_eff);

  assign in_stall_o       = q_full_i;
  assign q_push_o         = in_valid_i && !q_full_i;
  assign q_entry_o.sample = sample_i;
  assign q_entry_o.last   = last;

  always_comb begin
    count_d = count_q;
    if (q_push_o) begin
      count_d = last ? '0 : cnt_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

[rtl/gsb_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsb_queue
// Short fifo of tagged samples between the front and the back end.
// ----------------------------------------------------------------------------
module gsb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gsb_pkg::qent_t  entry_i,
  input  logic            pop_i,
  output gsb_pkg::qent_t  entry_o,
  output gsb_pkg::qstat_t status_o
);
  import gsb_pkg::*;

  qent_t             entries_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    if (p == QPTR_W'(Q_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  assign entry_o        = entries_q[rd_ptr_q];
  assign status_o.count = count_q;
  assign status_o.full  = (count_q == QCNT_W'(Q_DEPTH));
  assign status_o.empty = (count_q == '0);

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

[rtl/gsb_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsb_back
// Runs the recurrence and the block-end projection on one shared multiplier,
// each product as a high and a low partial product, then the rounded sum.
// ----------------------------------------------------------------------------
module gsb_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  input  gsb_pkg::qent_t                   q_entry_i,
  output logic                             q_pop_o,
  input  gsb_pkg::cfg_t                    cfg_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [gsb_pkg::OUT_W-1:0] real_part_o,
  output logic signed [gsb_pkg::OUT_W-1:0] imag_part_o
);
  import gsb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MH,
    S_ML,
    S_SUM,
    S_APPLY,
    S_OUTP
  } state_e;

  typedef enum logic [2:0] {
    ST_REC,
    ST_D,
    ST_E,
    ST_RE,
    ST_IM
  } step_e;

  localparam logic [FULL_W-1:0] RND_REC = FULL_W'(1) << (SH_REC - 1);
  localparam logic [FULL_W-1:0] RND_CS  = FULL_W'(1) << (SH_CS - 1);
  localparam logic [FULL_W-1:0] RND_OUT = FULL_W'(1) << (SH_OUT - 1);

  state_e                     state_q;
  step_e                      step_q;
  logic                       last_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [DLY_W-1:0]    q1_q, q2_q;
  logic signed [PROD_W-1:0]   ph_q, pl_q;
  logic signed [RES_W-1:0]    r_q, r_d;
  logic signed [OPA_W-1:0]    d_q, e_q, d_c;
  logic signed [OUT_W-1:0]    re_q;
  logic                       out_vld_q;
  logic signed [OUT_W-1:0]    real_q, imag_q;

  logic signed [OPA_W-1:0]    opa;
  logic signed [OPB_W-1:0]    opb;
  logic signed [HI_W-1:0]     mul_a;
  logic signed [PROD_W-1:0]   prod;
  logic signed [FULL_W-1:0]   full;
  logic [FULL_W-1:0]          rnd;
  logic signed [RES_W-1:0]    acc;
  logic signed [DLY_W-1:0]    q0_c;
  logic                       out_free;

  function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [RES_W-1:0] v);
    logic signed [DLY_W-1:0] res;
    if ((&v[RES_W-1:DLY_W-1]) || !(|v[RES_W-1:DLY_W-1])) begin
      res = v[DLY_W-1:0];
    end else if (v[RES_W-1]) begin
      res = {1'b1, {(DLY_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(DLY_W-1){1'b1}}};
    end
    return res;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [RES_W-1:0] v);
    logic signed [OUT_W-1:0] res;
    if ((&v[RES_W-1:OUT_W-1]) || !(|v[RES_W-1:OUT_W-1])) begin
      res = v[OUT_W-1:0];
    end else if (v[RES_W-1]) begin
      res = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return res;
  endfunction

  // operand selection per step
  always_comb begin
    case (step_q)
      ST_REC: begin
        opa = {{(OPA_W-DLY_W){q1_q[DLY_W-1]}}, q1_q};
        opb = {cfg_i.cos_coeff[COEF_W-1], cfg_i.cos_coeff};
      end
      ST_D: begin
        opa = {{(OPA_W-DLY_W){q2_q[DLY_W-1]}}, q2_q};
        opb = {cfg_i.cos_coeff[COEF_W-1], cfg_i.cos_coeff};
      end
      ST_E: begin
        opa = {{(OPA_W-DLY_W){q2_q[DLY_W-1]}}, q2_q};
        opb = {cfg_i.sin_coeff[COEF_W-1], cfg_i.sin_coeff};
      end
      ST_RE: begin
        opa = d_q;
        opb = {{(OPB_W-RECIP_W){1'b0}}, cfg_i.recip};
      end
      ST_IM: begin
        opa = e_q;
        opb = {{(OPB_W-RECIP_W){1'b0}}, cfg_i.recip};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // high part is signed, low part is an unsigned 24-bit slice
  assign mul_a = (state_q == S_MH) ? opa[OPA_W-1:LO_W]
                                   : {{(HI_W-LO_W){1'b0}}, opa[LO_W-1:0]};
  assign prod  = mul_a * opb;

  always_comb begin
    case (step_q)
      ST_REC:       rnd = RND_REC;
      ST_D, ST_E:   rnd = RND_CS;
      default:      rnd = RND_OUT;
    endcase
    full = {ph_q, {LO_W{1'b0}}} + {{(FULL_W-PROD_W){pl_q[PROD_W-1]}}, pl_q} + rnd;
    case (step_q)
      ST_REC:       r_d = RES_W'(full >>> SH_REC);
      ST_D, ST_E:   r_d = RES_W'(full >>> SH_CS);
      default:      r_d = RES_W'(full >>> SH_OUT);
    endcase
  end

  always_comb begin
    acc  = r_q - {{(RES_W-DLY_W){q2_q[DLY_W-1]}}, q2_q}
               + {{(RES_W-SAMPLE_W-X_SHIFT){x_q[SAMPLE_W-1]}}, x_q, {X_SHIFT{1'b0}}};
    q0_c = sat_dly(acc);
    d_c  = {{(OPA_W-DLY_W){q1_q[DLY_W-1]}}, q1_q} - r_q[OPA_W-1:0];
  end

  assign out_free = !out_vld_q || !out_stall_i;
  assign q_pop_o  = q_valid_i && ((state_q == S_IDLE) ||
                    (state_q == S_APPLY && step_q == ST_REC && !last_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= ST_REC;
      last_q    <= 1'b0;
      x_q       <= '0;
      q1_q      <= '0;
      q2_q      <= '0;
      ph_q      <= '0;
      pl_q      <= '0;
      r_q       <= '0;
      d_q       <= '0;
      e_q       <= '0;
      re_q      <= '0;
      out_vld_q <= 1'b0;
      real_q    <= '0;
      imag_q    <= '0;
    end else begin
      // a new result loaded this cycle keeps valid high
      if (out_vld_q && !out_stall_i && !(state_q == S_OUTP && out_free)) begin
        out_vld_q <= 1'b0;
      end
      if (q_pop_o) begin
        x_q    <= q_entry_i.sample;
        last_q <= q_entry_i.last;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            step_q  <= ST_REC;
            state_q <= S_MH;
          end
        end
        S_MH: begin
          ph_q    <= prod;
          state_q <= S_ML;
        end
        S_ML: begin
          pl_q    <= prod;
          state_q <= S_SUM;
        end
        S_SUM: begin
          r_q     <= r_d;
          state_q <= S_APPLY;
        end
        S_APPLY: begin
          case (step_q)
            ST_REC: begin
              q2_q <= q1_q;
              q1_q <= q0_c;
              if (last_q) begin
                step_q  <= ST_D;
                state_q <= S_MH;
              end else if (q_valid_i) begin
                state_q <= S_MH;
              end else begin
                state_q <= S_IDLE;
              end
            end
            ST_D: begin
              d_q     <= d_c;
              step_q  <= ST_E;
              state_q <= S_MH;
            end
            ST_E: begin
              e_q     <= r_q[OPA_W-1:0];
              step_q  <= ST_RE;
              state_q <= S_MH;
            end
            ST_RE: begin
              re_q    <= sat_out(r_q);
              step_q  <= ST_IM;
              state_q <= S_MH;
            end
            default: begin
              state_q <= S_OUTP;
            end
          endcase
        end
        S_OUTP: begin
          if (out_free) begin
            real_q    <= re_q;
            imag_q    <= sat_out(r_q);
            out_vld_q <= 1'b1;
            q1_q      <= '0;
            q2_q      <= '0;
            step_q    <= ST_REC;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign real_part_o = real_q;
  assign imag_part_o = imag_q;

endmodule
`default_nettype wire

[rtl/goertzel_single_bin.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// goertzel_single_bin
// Single-bin goertzel detector: front tags block ends, a two-entry queue
// decouples it from the back end that owns the delays and the multiplier.
// ----------------------------------------------------------------------------
// per sample: two partial products, rounded sum and update; the partial products
//   come from the one 26x33 multiplier; a new sample is taken only after the previous one is updated
// block end: the last sample adds the d, e, real and imaginary products, then the output
// reset: delays, sample count, queue and output cleared; registers to defaults
// ----------------------------------------------------------------------------
module goertzel_single_bin (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [gsb_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [gsb_pkg::OUT_W-1:0]     real_part_o,
  output logic signed [gsb_pkg::OUT_W-1:0]     imag_part_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [gsb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [gsb_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import gsb_pkg::*;

  logic [BLEN_W-1:0] block_length_q;
  cfg_t              cfg_q;
  logic              q_push, q_pop;
  qent_t             q_wr_entry, q_rd_entry;
  qstat_t            q_st;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q  <= BLEN_W'(256);
      cfg_q.cos_coeff <= COEF_W'(32'sd1073741824);
      cfg_q.sin_coeff <= '0;
      cfg_q.recip     <= RECIP_W'(8388608);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_BLOCK_LENGTH: block_length_q  <= cfg_data_i[BLEN_W-1:0];
        REG_COS_COEFF:    cfg_q.cos_coeff <= cfg_data_i[COEF_W-1:0];
        REG_SIN_COEFF:    cfg_q.sin_coeff <= cfg_data_i[COEF_W-1:0];
        REG_HALF_RECIP:   cfg_q.recip     <= cfg_data_i[RECIP_W-1:0];
        default:          block_length_q  <= block_length_q;
      endcase
    end
  end

  gsb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .block_length_i (block_length_q),
    .q_full_i       (q_st.full),
    .q_push_o       (q_push),
    .q_entry_o      (q_wr_entry)
  );

  gsb_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .entry_i  (q_wr_entry),
    .pop_i    (q_pop),
    .entry_o  (q_rd_entry),
    .status_o (q_st)
  );

  gsb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (!q_st.empty),
    .q_entry_i   (q_rd_entry),
    .q_pop_o     (q_pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .real_part_o (real_part_o),
    .imag_part_o (imag_part_o)
  );

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_st.empty)
    else $error("back end took from an empty queue");

  a_count_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |=> (q_st.count == $past(q_st.count) + 1'b1))
    else $error("queue count lost a request");

  a_count_down : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && !q_push) |=> (q_st.count == $past(q_st.count) - 1'b1))
    else $error("queue count out of step with pops");

endmodule
`default_nettype wire
